// ----- sv/fum_pkg.sv -----
// ----------------------------------------------------------------------------
// fum_pkg
// shared types, widths and the sine table of the fsk uart modulator
// ----------------------------------------------------------------------------
package fum_pkg;

    // sizing
    localparam int TABLE_SIZE  = 256;
    localparam int QUEUE_DEPTH = 128;
    localparam int SAMPLE_BITS = 12;
    localparam int DATA_BITS   = 8;

    localparam int PHASE_W     = $clog2(TABLE_SIZE);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 8;
    localparam int TPB_W       = 10;
    localparam int STEP_W      = 8;
    localparam int BITPOS_W    = 4;
    localparam int PHASE_SUM_W = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP    = 2'd2;

    localparam logic [TPB_W-1:0]  TPB_RESET        = 10'd32;
    localparam logic [STEP_W-1:0] MARK_STEP_RESET  = 8'd8;
    localparam logic [STEP_W-1:0] SPACE_STEP_RESET = 8'd15;

    // item commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // sine polynomial coefficients, q28
    localparam longint unsigned SIN_A1 = 64'd421657428;
    localparam longint unsigned SIN_A3 = 64'd173399667;
    localparam longint unsigned SIN_A5 = 64'd21392326;
    localparam longint unsigned SIN_A7 = 64'd1256749;
    localparam longint unsigned SIN_A9 = 64'd43068;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t sine_rom_t [TABLE_SIZE];

    typedef struct packed {
        logic [TPB_W-1:0]  ticks_per_bit;
        logic [STEP_W-1:0] mark_step;
        logic [STEP_W-1:0] space_step;
    } cfg_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } queue_ctl_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [BYTE_W-1:0] head;
    } queue_stat_t;

    typedef struct packed {
        sample_t            sample;
        logic [PHASE_W-1:0] index;
        logic               sending;
    } tx_result_t;

    // table build, evaluated at elaboration only
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned t;
        longint unsigned quad;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned acc;
        longint unsigned mag;
        longint unsigned mid;
        longint unsigned amp;
        mid = 64'd1 << (SAMPLE_BITS - 1);
        amp = mid - 64'd1;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            t    = ((longint'(i) << 16) / TABLE_SIZE) & 64'hFFFF;
            quad = t >> 14;
            z    = t & 64'h3FFF;
            if (quad[0])
            begin
                z = 64'd16384 - z;
            end
            z2  = (z * z) >> 14;
            acc = SIN_A9;
            acc = SIN_A7 - ((acc * z2) >> 14);
            acc = SIN_A5 - ((acc * z2) >> 14);
            acc = SIN_A3 - ((acc * z2) >> 14);
            acc = SIN_A1 - ((acc * z2) >> 14);
            acc = (acc * z) >> 14;
            mag = (acc * amp + (64'd1 << 27)) >> 28;
            if (mag > amp)
            begin
                mag = amp;
            end
            rom[i] = (quad < 64'd2) ? SAMPLE_BITS'(mid + mag) : SAMPLE_BITS'(mid - mag);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- sv/fum_ram.sv -----
// ----------------------------------------------------------------------------
// fum_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/fum_queue.sv -----
// ----------------------------------------------------------------------------
// fum_queue
// transmit byte queue with the front byte held in a head register
// ----------------------------------------------------------------------------
module fum_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fum_pkg::queue_ctl_t  ctl,
    output fum_pkg::queue_stat_t stat
);
    import fum_pkg::*;

    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic               head_load_reg;
    logic [BYTE_W-1:0]  head_reg, head_next;
    logic [QPTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0]  rd_data;
    logic               full, empty, do_push;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = ctl.push && !full;
    // the byte behind the head, fetched on the pop edge
    assign rd_addr = ptr_inc(rd_ptr_reg);

    fum_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (ctl.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        if (do_push)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            fill_next   = fill_reg + 1'b1;
        end
        if (ctl.pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            fill_next   = fill_reg - 1'b1;
        end
        // a push into an empty queue goes straight to the head
        if (do_push && empty)
        begin
            head_next = ctl.data;
        end
        else if (head_load_reg)
        begin
            head_next = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            head_load_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            head_load_reg <= ctl.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    assign stat.full  = full;
    assign stat.empty = empty;
    assign stat.head  = head_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QFILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !empty)
        else $error("pop from empty queue");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (full || empty) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !ctl.push)
        else $error("push and pop in one cycle");

endmodule

// ----- sv/fum_tx.sv -----
// ----------------------------------------------------------------------------
// fum_tx
// serial framing state, phase accumulator and sine lookup for one tick
// ----------------------------------------------------------------------------
module fum_tx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  fum_pkg::cfg_t        cfg,
    input  fum_pkg::queue_stat_t qstat,
    output logic                 pop,
    output fum_pkg::tx_result_t  res
);
    import fum_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_START = 2'd1,
        MODE_MARK  = 2'd2,
        MODE_SPACE = 2'd3
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [BITPOS_W-1:0]  bitpos_reg, bitpos_next;
    logic [TPB_W-1:0]     tcount_reg, tcount_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [TPB_W:0]       count_inc;
    logic [PHASE_SUM_W-1:0] phase_sum;
    logic                 space;

    assign count_inc = {1'b0, tcount_reg} + 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        bitpos_next = bitpos_reg;
        tcount_next = tcount_reg;
        shift_next  = shift_reg;
        pop         = 1'b0;
        space       = 1'b0;
        if (count_inc < {1'b0, cfg.ticks_per_bit})
        begin
            tcount_next = count_inc[TPB_W-1:0];
            space       = mode_reg inside {MODE_START, MODE_SPACE};
        end
        else
        begin
            tcount_next = TPB_W'(1);
            if (mode_reg == MODE_IDLE)
            begin
                if (!qstat.empty)
                begin
                    shift_next = qstat.head;
                    pop        = tick;
                    mode_next  = MODE_START;
                    space      = 1'b1;
                end
            end
            else
            begin
                bitpos_next = (mode_reg == MODE_START) ? '0 : bitpos_reg + 1'b1;
                if (bitpos_next >= BITPOS_W'(DATA_BITS))
                begin
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    space     = !shift_reg[bitpos_next[$clog2(DATA_BITS)-1:0]];
                    mode_next = space ? MODE_SPACE : MODE_MARK;
                end
            end
        end
        phase_sum  = PHASE_SUM_W'(phase_reg)
                   + PHASE_SUM_W'(space ? cfg.space_step : cfg.mark_step);
        phase_next = PHASE_W'(phase_sum % TABLE_SIZE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            bitpos_reg <= '0;
            tcount_reg <= '0;
            shift_reg  <= '0;
            phase_reg  <= '0;
        end
        else if (tick)
        begin
            mode_reg   <= mode_next;
            bitpos_reg <= bitpos_next;
            tcount_reg <= tcount_next;
            shift_reg  <= shift_next;
            phase_reg  <= phase_next;
        end
    end

    assign res.sample  = SINE_ROM[phase_reg];
    assign res.index   = phase_reg;
    assign res.sending = tick ? (mode_next != MODE_IDLE) : (mode_reg != MODE_IDLE);

endmodule

// ----- sv/fsk_uart_modulator_top.sv -----
// ----------------------------------------------------------------------------
// fsk_uart_modulator_top
// byte queue to fsk audio samples with asynchronous serial framing
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | command, data_byte
//  output   | out_valid / out_ready | accepted, dac_sample, phase_index, sending
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one item per cycle unless the result register waits for out_ready:
//  an item is held in the input register, is worked in one pass (queue
//  update, framing step, phase add, sine lookup) and lands in the result
//  register. the result register and the input register part the two
//  sides: one more item is taken while a result waits for out_ready
//  the queue ram has a registered read; its head byte sits in a register
//  and is refilled the cycle after each pop
//  rst_n clears control state at once; cfg_ready is always high
//
module fsk_uart_modulator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // item input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [fum_pkg::BYTE_W-1:0]        data_byte,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [fum_pkg::SAMPLE_BITS-1:0]   dac_sample,
    output logic [fum_pkg::INDEX_W-1:0]       phase_index,
    output logic                              sending,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fum_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fum_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fum_pkg::*;

    // input register
    logic              item_vld_reg;
    logic              cmd_reg;
    logic [BYTE_W-1:0] byte_reg;

    // result register
    logic                   out_vld_reg;
    logic                   accepted_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic                   sending_reg;

    cfg_t        cfg_reg;
    queue_ctl_t  qctl;
    queue_stat_t qstat;
    tx_result_t  txres;
    logic        fire, is_tick, pop, in_xfer;

    // the worked item moves on when the result slot is free or being drained
    assign fire     = item_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || fire;
    assign in_xfer  = in_valid && in_ready;
    assign is_tick  = fire && (cmd_reg == CMD_TICK);

    assign qctl.push = fire && (cmd_reg == CMD_PUSH);
    assign qctl.pop  = pop;
    assign qctl.data = byte_reg;

    fum_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl),
        .stat  (qstat)
    );

    fum_tx u_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (is_tick),
        .cfg   (cfg_reg),
        .qstat (qstat),
        .pop   (pop),
        .res   (txres)
    );

    // config writes, unknown index dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_bit <= TPB_RESET;
            cfg_reg.mark_step     <= MARK_STEP_RESET;
            cfg_reg.space_step    <= SPACE_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TICKS_PER_BIT: cfg_reg.ticks_per_bit <= cfg_data[TPB_W-1:0];
                CFG_MARK_STEP:     cfg_reg.mark_step     <= cfg_data[STEP_W-1:0];
                CFG_SPACE_STEP:    cfg_reg.space_step    <= cfg_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_vld_reg <= 1'b0;
            end
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= command;
            byte_reg <= data_byte;
        end
        if (fire)
        begin
            // push reports queue room, tick reports the sample
            accepted_reg <= qctl.push && !qstat.full;
            sample_reg   <= is_tick ? txres.sample : '0;
            index_reg    <= is_tick ? INDEX_W'(txres.index) : '0;
            sending_reg  <= txres.sending;
        end
    end

    assign out_valid   = out_vld_reg;
    assign accepted    = accepted_reg;
    assign dac_sample  = sample_reg;
    assign phase_index = index_reg;
    assign sending     = sending_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_vld_reg |-> in_ready)
        else $error("input blocked with empty input register");

    a_fire_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ready) |-> !fire)
        else $error("result overwritten while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_vld_reg)
        else $error("worked item produced no result");

endmodule
